// ===== src/hcb_pkg.sv =====
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF   = 1024;
    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int WEIGHT_W          = 40;
    localparam int NODE_WEIGHT_W     = 50;
    localparam int CODE_W            = 16;
    localparam int DEPTH_W           = 5;
    localparam int RANK_W            = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_INIT  = 12'b0000_0000_0010,
        ST_CHECK = 12'b0000_0000_0100,
        ST_RD1   = 12'b0000_0000_1000,
        ST_DEC1  = 12'b0000_0001_0000,
        ST_RD2   = 12'b0000_0010_0000,
        ST_DEC2  = 12'b0000_0100_0000,
        ST_WRN   = 12'b0000_1000_0000,
        ST_CINIT = 12'b0001_0000_0000,
        ST_CRD   = 12'b0010_0000_0000,
        ST_CW0   = 12'b0100_0000_0000,
        ST_CW1   = 12'b1000_0000_0000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic read;
        logic init;
        logic take_rd;
        logic take_dec;
        logic take_second;
        logic node_wr;
        logic cinit;
        logic crd;
        logic cw0;
        logic cw1;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rd_free;
        logic loop;
        logic have_root;
        logic p_zero;
    } t_stat;

endpackage

// ===== src/hcb_if.sv =====
interface hcb_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [hcb_pkg::WEIGHT_W-1:0] weight;
    logic                       last;
    logic [hcb_pkg::RANK_W-1:0] rank;

    modport source (output valid, output cmd, output weight, output last, output rank,
                    input ready);
    modport sink   (input valid, input cmd, input weight, input last, input rank,
                    output ready);
endinterface

interface hcb_out_if;
    logic                          valid;
    logic                          ready;
    logic [hcb_pkg::RANK_W-1:0]    out_rank;
    logic [hcb_pkg::CODE_W-1:0]    code_word;
    logic [hcb_pkg::DEPTH_W-1:0]   code_length;
    logic                          has_code;

    modport source (output valid, output out_rank, output code_word, output code_length,
                    output has_code, input ready);
    modport sink   (input valid, input out_rank, input code_word, input code_length,
                    input has_code, output ready);
endinterface

// ===== src/hcb_ctrl.sv =====
module hcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_cmd,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  hcb_pkg::t_stat i_stat,
    output hcb_pkg::t_cmd  o_cmd
);

    hcb_pkg::t_state r_state, n_state;
    logic accept;

    assign o_in_ready = (r_state == hcb_pkg::ST_IDLE) && i_stat.rd_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = accept && (i_in_cmd == hcb_pkg::CMD_LOAD);
        o_cmd.read        = accept && (i_in_cmd == hcb_pkg::CMD_READ);
        o_cmd.init        = (r_state == hcb_pkg::ST_INIT);
        o_cmd.take_rd     = (r_state == hcb_pkg::ST_RD1) || (r_state == hcb_pkg::ST_RD2);
        o_cmd.take_dec    = (r_state == hcb_pkg::ST_DEC1) || (r_state == hcb_pkg::ST_DEC2);
        o_cmd.take_second = (r_state == hcb_pkg::ST_DEC2);
        o_cmd.node_wr     = (r_state == hcb_pkg::ST_WRN);
        o_cmd.cinit       = (r_state == hcb_pkg::ST_CINIT);
        o_cmd.crd         = (r_state == hcb_pkg::ST_CRD);
        o_cmd.cw0         = (r_state == hcb_pkg::ST_CW0);
        o_cmd.cw1         = (r_state == hcb_pkg::ST_CW1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcb_pkg::ST_IDLE: begin
                if (o_cmd.load && i_in_last) n_state = hcb_pkg::ST_INIT;
            end
            hcb_pkg::ST_INIT:  n_state = hcb_pkg::ST_CHECK;
            hcb_pkg::ST_CHECK: begin
                if (i_stat.loop)           n_state = hcb_pkg::ST_RD1;
                else if (i_stat.have_root) n_state = hcb_pkg::ST_CINIT;
                else                       n_state = hcb_pkg::ST_IDLE;
            end
            hcb_pkg::ST_RD1:   n_state = hcb_pkg::ST_DEC1;
            hcb_pkg::ST_DEC1:  n_state = hcb_pkg::ST_RD2;
            hcb_pkg::ST_RD2:   n_state = hcb_pkg::ST_DEC2;
            hcb_pkg::ST_DEC2:  n_state = hcb_pkg::ST_WRN;
            hcb_pkg::ST_WRN:   n_state = hcb_pkg::ST_CHECK;
            hcb_pkg::ST_CINIT: n_state = hcb_pkg::ST_CRD;
            hcb_pkg::ST_CRD:   n_state = hcb_pkg::ST_CW0;
            hcb_pkg::ST_CW0:   n_state = hcb_pkg::ST_CW1;
            hcb_pkg::ST_CW1: begin
                n_state = i_stat.p_zero ? hcb_pkg::ST_IDLE : hcb_pkg::ST_CRD;
            end
            default:           n_state = hcb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/hcb_datapath.sv =====
module hcb_datapath #(
    parameter int MAX_SYMBOLS   = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcb_pkg::t_cmd                 i_cmd,
    output hcb_pkg::t_stat                o_stat,
    input  logic [hcb_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic                          i_last,
    input  logic [hcb_pkg::RANK_W-1:0]    i_rank,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [hcb_pkg::RANK_W-1:0]    o_out_rank,
    output logic [hcb_pkg::CODE_W-1:0]    o_code_word,
    output logic [hcb_pkg::DEPTH_W-1:0]   o_code_length,
    output logic                          o_has_code
);

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int REF_W = IDX_W + 2;                  // {none, node, index}
    localparam int WW    = hcb_pkg::WEIGHT_W;
    localparam int NW    = hcb_pkg::NODE_WEIGHT_W;
    localparam int CW    = hcb_pkg::CODE_W;
    localparam int DW    = hcb_pkg::DEPTH_W;
    localparam int NC_W  = 1 + DW + CW;                // {valid, depth, code}
    localparam int SC_W  = DW + CW;                    // {length, code}

    logic [WW-1:0]      mem_sym_w   [MAX_SYMBOLS];
    logic [NW-1:0]      mem_node_w  [MAX_SYMBOLS];
    logic [2*REF_W-1:0] mem_node_ch [MAX_SYMBOLS];
    logic [NC_W-1:0]    mem_node_cd [MAX_SYMBOLS];
    logic [SC_W-1:0]    mem_sym_cd  [MAX_SYMBOLS];

    logic [CNT_W-1:0]   r_count, r_rem, r_head, r_tail;
    logic               r_closed;
    logic [IDX_W-1:0]   r_p;
    logic [REF_W-1:0]   r_a_ref, r_b_ref;
    logic [NW-1:0]      r_a_w, r_b_w;
    logic [WW-1:0]      r_sw_q;
    logic [NW-1:0]      r_nw_q;
    logic [2*REF_W-1:0] r_ch_q;
    logic [NC_W-1:0]    r_nc_q;
    logic [SC_W-1:0]    r_sc_q;

    // read pipeline: pending stage then output register
    logic                      r_pv, r_pok, r_ov;
    logic [hcb_pkg::RANK_W-1:0] r_prank;
    logic                      pend_move;

    logic [CNT_W-1:0] load_cnt;
    logic [CNT_W-1:0] rem_m1;
    logic             queued, pick_node;
    logic [REF_W-1:0] take_ref;
    logic [NW-1:0]    take_w;
    logic [NW:0]      sum;
    logic [NW-1:0]    sum_sat;

    logic [REF_W-1:0] child;
    logic             p_valid, c_valid;
    logic [DW-1:0]    p_depth, c_depth;
    logic [CW-1:0]    p_code, c_code;
    logic [IDX_W-1:0] rank_idx;

    assign load_cnt = r_closed ? '0 : r_count;
    assign rem_m1   = r_rem - CNT_W'(1);
    assign queued   = r_head < r_tail;
    assign pick_node = (r_rem == '0) || (queued && (r_nw_q < NW'(r_sw_q)));

    always_comb begin
        if (pick_node) begin
            take_ref = queued ? {1'b0, 1'b1, r_head[IDX_W-1:0]} : {1'b1, 1'b0, IDX_W'(0)};
            take_w   = queued ? r_nw_q : '0;
        end else begin
            take_ref = {1'b0, 1'b0, rem_m1[IDX_W-1:0]};
            take_w   = NW'(r_sw_q);
        end
    end

    assign sum     = {1'b0, r_a_w} + {1'b0, r_b_w};
    assign sum_sat = sum[NW] ? {NW{1'b1}} : sum[NW-1:0];

    // code sweep: children inherit parent's code, right child adds a 1 at depth
    assign child   = i_cmd.cw1 ? r_ch_q[2*REF_W-1:REF_W] : r_ch_q[REF_W-1:0];
    assign p_valid = r_nc_q[NC_W-1];
    assign p_depth = r_nc_q[CW +: DW];
    assign p_code  = r_nc_q[CW-1:0];
    assign c_valid = p_valid && (p_depth < DW'(MAX_CODE_BITS));
    assign c_depth = c_valid ? p_depth + DW'(1) : '0;
    assign c_code  = !c_valid ? '0
                   : (i_cmd.cw1 ? (p_code | (CW'(1) << p_depth[3:0])) : p_code);

    assign rank_idx  = IDX_W'(i_rank);
    assign pend_move = !r_ov || i_out_ready;

    assign o_stat.rd_free   = !r_pv || pend_move;
    assign o_stat.loop      = ((r_rem != '0) || ((r_tail - r_head) > CNT_W'(1)))
                              && (r_tail < CNT_W'(MAX_SYMBOLS));
    assign o_stat.have_root = queued;
    assign o_stat.p_zero    = (r_p == '0);

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (load_cnt < CNT_W'(MAX_SYMBOLS))) begin
            mem_sym_w[load_cnt[IDX_W-1:0]] <= i_weight;
        end
        if (i_cmd.take_rd) begin
            r_sw_q <= mem_sym_w[rem_m1[IDX_W-1:0]];
            r_nw_q <= mem_node_w[r_head[IDX_W-1:0]];
        end
        if (i_cmd.node_wr) begin
            mem_node_w[r_tail[IDX_W-1:0]]  <= sum_sat;
            mem_node_ch[r_tail[IDX_W-1:0]] <= {r_b_ref, r_a_ref};
        end
        if (i_cmd.crd) begin
            r_ch_q <= mem_node_ch[r_p];
            r_nc_q <= mem_node_cd[r_p];
        end
        if (i_cmd.cinit) begin
            mem_node_cd[r_head[IDX_W-1:0]] <= {1'b1, DW'(0), CW'(0)};
        end else if ((i_cmd.cw0 || i_cmd.cw1) && !child[REF_W-1]) begin
            if (child[REF_W-2]) begin
                mem_node_cd[child[IDX_W-1:0]] <= {c_valid, c_depth, c_code};
            end
        end
        if ((i_cmd.cw0 || i_cmd.cw1) && !child[REF_W-1] && !child[REF_W-2]) begin
            mem_sym_cd[child[IDX_W-1:0]] <= {c_depth, c_code};
        end
        if (i_cmd.read) begin
            r_sc_q <= mem_sym_cd[rank_idx];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_dec) begin
            if (i_cmd.take_second) begin
                r_b_ref <= take_ref;
                r_b_w   <= take_w;
            end else begin
                r_a_ref <= take_ref;
                r_a_w   <= take_w;
            end
        end
        if (i_cmd.cinit) r_p <= r_head[IDX_W-1:0];
        else if (i_cmd.cw1) r_p <= r_p - IDX_W'(1);
        if (i_cmd.read) begin
            r_prank <= i_rank;
            r_pok   <= r_closed && (32'(i_rank) < 32'(r_count));
        end
        if (pend_move && r_pv) begin
            o_out_rank    <= r_prank;
            o_has_code    <= r_pok && (r_sc_q[CW +: DW] != '0);
            o_code_word   <= (r_pok && (r_sc_q[CW +: DW] != '0)) ? r_sc_q[CW-1:0] : '0;
            o_code_length <= r_pok ? r_sc_q[CW +: DW] : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_closed <= 1'b0;
            r_rem    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_closed <= i_last;
                r_count  <= (load_cnt < CNT_W'(MAX_SYMBOLS)) ? load_cnt + CNT_W'(1) : load_cnt;
            end
            if (i_cmd.init) begin
                r_rem  <= r_count;
                r_head <= '0;
                r_tail <= '0;
            end
            if (i_cmd.take_dec) begin
                if (pick_node) begin
                    if (queued) r_head <= r_head + CNT_W'(1);
                end else begin
                    r_rem <= rem_m1;
                end
            end
            if (i_cmd.node_wr) r_tail <= r_tail + CNT_W'(1);
            if (pend_move) r_ov <= r_pv;
            if (i_cmd.read) r_pv <= 1'b1;
            else if (pend_move) r_pv <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;

endmodule

// ===== src/huffman_code_builder.sv =====
// Huffman code builder, two-queue construction, depth limited.
// Input channel i_in (valid/ready): cmd = load carries one weight, heaviest
// first; last on a load closes the set and starts the build. cmd = read asks
// for the code of one symbol rank.
// Output channel o_out: one item per read with rank, code word (first bit in
// bit 0), length and has_code. Loads give no output.
// Loads are accepted back to back while the input is ready. A read's result
// passes through the pending stage and then the output register; reads stream at
// one per cycle while the receiver keeps up. Build: each merged node takes a
// loop check, two queue reads and compares, and one node write; then the
// top-down code sweep reads each node and writes its two children. The input
// is not ready during the build.
// Reset clears counts, queue pointers and the output valid; weight and node
// memories need no clearing, every loaded rank's code is rewritten by each build.
// When the receiver stalls, the result holds in the output register, one more
// read may sit in the pending stage, then the input stops being ready.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS   = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcb_in_if.sink     i_in,
    hcb_out_if.source  o_out
);

    hcb_pkg::t_cmd  cmd;
    hcb_pkg::t_stat stat;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hcb_datapath #(
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_weight      (i_in.weight),
        .i_last        (i_in.last),
        .i_rank        (i_in.rank),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_rank    (o_out.out_rank),
        .o_code_word   (o_out.code_word),
        .o_code_length (o_out.code_length),
        .o_has_code    (o_out.has_code)
    );

endmodule

// ===== src/hcb_checker.sv =====
module hcb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hcb_pkg::CODE_W-1:0]   i_code_word,
    input logic [hcb_pkg::DEPTH_W-1:0]  i_code_length,
    input logic                         i_has_code
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_word))
        else $error("output item dropped or changed under stall");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_code |->
            (i_code_length != '0) && (i_code_length <= 5'd16))
        else $error("bad code length");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_code |-> (i_code_length == '0) && (i_code_word == '0))
        else $error("no-code item carries bits");

    a_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_code |-> ((i_code_word >> i_code_length) == '0))
        else $error("code bits above length");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_code_word   (o_out.code_word),
    .i_code_length (o_out.code_length),
    .i_has_code    (o_out.has_code)
);
